FILE: design/prr_pkg.sv
// Shared types and constants for the priority FIFO/round-robin scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package prr_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int LEVELS_DEF = 32;
    localparam int NOW_W = 12;
    localparam logic [NOW_W-1:0] TIME_LIMIT_RESET = 12'd2048;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] task_arrival;
        logic [15:0] task_priority;
        logic [15:0] task_compute;
        logic        task_round_robin;
    } in_item_t;

    typedef struct packed {
        logic             accepted;
        logic             ran;
        logic [3:0]       task_slot;
        logic             active;
        logic [NOW_W-1:0] now;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADV,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_SEL,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan_step;
        logic advance;
        logic rot_rd;
        logic rot_wr;
        logic sel;
        logic run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_scan;
        logic rot_do;
        logic any_ne;
    } status_t;

endpackage

FILE: design/prr_controller.sv
// Sequencer for the scheduler: walks one tick item through scan, advance,
// rotation, selection and run, and owns the handshake flags. Uses prr_pkg.
module prr_controller
    import prr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    in_func,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = stat.count_zero ? ST_ADV : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.last_scan)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = stat.rot_do ? ST_ROT_RD : ST_SEL;
            end
            ST_ROT_RD:
            begin
                cmd.rot_rd = 1'b1;
                state_next = ST_ROT_WR;
            end
            ST_ROT_WR:
            begin
                cmd.rot_wr = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                cmd.sel    = 1'b1;
                state_next = stat.any_ne ? ST_RUN : ST_DONE;
            end
            ST_RUN:
            begin
                cmd.run    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/prr_datapath.sv
// Task table, ready queues (one shared memory), clock and result register
// of the scheduler. Driven by prr_controller commands; uses prr_pkg.
module prr_datapath
    import prr_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int LEVELS    = LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          stat,
    input  in_item_t         in_data,
    input  logic             cfg_we,
    input  logic [NOW_W-1:0] cfg_wdata,
    output out_item_t        out_data
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int QD = LEVELS * MAX_TASKS;
    localparam int AW = $clog2(QD);

    logic [15:0]      arrival_reg  [MAX_TASKS];
    logic [LW-1:0]    level_reg    [MAX_TASKS];
    logic [15:0]      length_reg   [MAX_TASKS];
    logic [15:0]      progress_reg [MAX_TASKS];
    logic             policy_reg   [MAX_TASKS];
    logic [CW-1:0]    count_reg;
    logic [SW-1:0]    head_reg [LEVELS];
    logic [SW-1:0]    tail_reg [LEVELS];
    logic [CW-1:0]    fill_reg [LEVELS];
    logic [SW-1:0]    queue_mem [QD];
    logic [SW-1:0]    rdata_reg;
    logic [SW-1:0]    idx_reg;
    logic             pending_reg;
    logic [LW-1:0]    rot_lv_reg;
    logic [LW-1:0]    sel_lv_reg;
    logic [NOW_W-1:0] now_reg;
    logic [NOW_W-1:0] limit_reg;
    logic             future_reg;
    logic             res_accepted_reg;
    logic             res_ran_reg;
    logic [SW-1:0]    res_slot_reg;
    out_item_t        out_reg;

    logic [LEVELS-1:0] ne;
    logic [LW-1:0]     enc_lv;
    logic [NOW_W-1:0]  now_inc;
    logic [LW-1:0]     scan_lv;
    logic              scan_hit;
    logic              scan_future;
    logic [LW-1:0]     lv_sel;
    logic [SW-1:0]     head_sel;
    logic [SW-1:0]     tail_sel;
    logic [CW-1:0]     fill_sel;
    logic [AW-1:0]     base_addr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              push_ok;
    logic              store_we;
    logic [SW-1:0]     store_wdata;
    logic [SW-1:0]     run_slot;
    logic [15:0]       prog_inc;
    logic [15:0]       remain;
    logic              pri_ok;
    logic              load_ok;
    logic [SW-1:0]     load_slot;
    logic [7:0]        slot_wide;

    function automatic logic [SW-1:0] next_pos(input logic [SW-1:0] p);
        return (p == SW'(MAX_TASKS - 1)) ? '0 : p + SW'(1);
    endfunction

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            ne[l] = (fill_reg[l] != '0);
        end
    end

    // Lowest level number with a queued task has the highest priority.
    always_comb
    begin
        enc_lv = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (ne[l])
            begin
                enc_lv = LW'(l);
            end
        end
    end

    assign now_inc     = now_reg + NOW_W'(1);
    assign scan_lv     = level_reg[idx_reg];
    assign scan_hit    = (arrival_reg[idx_reg] == 16'(now_reg));
    assign scan_future = (arrival_reg[idx_reg] >= 16'(now_inc));

    always_comb
    begin
        if (cmd.scan_step)
        begin
            lv_sel = scan_lv;
        end
        else if (cmd.rot_rd || cmd.rot_wr)
        begin
            lv_sel = rot_lv_reg;
        end
        else if (cmd.sel)
        begin
            lv_sel = enc_lv;
        end
        else
        begin
            lv_sel = sel_lv_reg;
        end
    end

    assign head_sel  = head_reg[lv_sel];
    assign tail_sel  = tail_reg[lv_sel];
    assign fill_sel  = fill_reg[lv_sel];
    assign base_addr = AW'(lv_sel) * AW'(MAX_TASKS);
    assign rd_addr   = base_addr + AW'(head_sel);
    assign wr_addr   = base_addr + AW'(tail_sel);

    assign push_ok     = cmd.scan_step && scan_hit && (fill_sel < CW'(MAX_TASKS));
    assign store_we    = push_ok || cmd.rot_wr;
    assign store_wdata = cmd.rot_wr ? rdata_reg : idx_reg;

    assign run_slot = ({1'b0, rdata_reg} >= (SW + 1)'(MAX_TASKS)) ? '0 : rdata_reg;
    assign prog_inc = progress_reg[run_slot] + 16'd1;
    assign remain   = length_reg[run_slot] - prog_inc;

    assign pri_ok    = (in_data.task_priority != 16'd0) &&
                       (in_data.task_priority <= 16'(LEVELS));
    assign load_ok   = cmd.load && pri_ok && (count_reg < CW'(MAX_TASKS));
    assign load_slot = SW'(count_reg);

    assign stat.count_zero = (count_reg == '0);
    assign stat.last_scan  = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.rot_do     = pending_reg && ne[rot_lv_reg];
    assign stat.any_ne     = |ne;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            queue_mem[wr_addr] <= store_wdata;
        end
        rdata_reg <= queue_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            arrival_reg[load_slot] <= in_data.task_arrival;
            level_reg[load_slot]   <= LW'(in_data.task_priority - 16'd1);
            length_reg[load_slot]  <= in_data.task_compute;
            policy_reg[load_slot]  <= in_data.task_round_robin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                progress_reg[i] <= '0;
            end
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
            count_reg        <= '0;
            idx_reg          <= '0;
            pending_reg      <= 1'b0;
            rot_lv_reg       <= '0;
            sel_lv_reg       <= '0;
            now_reg          <= '0;
            limit_reg        <= TIME_LIMIT_RESET;
            future_reg       <= 1'b0;
            res_accepted_reg <= 1'b0;
            res_ran_reg      <= 1'b0;
            res_slot_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                res_accepted_reg <= load_ok;
                res_ran_reg      <= 1'b0;
                res_slot_reg     <= load_ok ? load_slot : '0;
                if (load_ok)
                begin
                    count_reg               <= count_reg + CW'(1);
                    progress_reg[load_slot] <= '0;
                    if (in_data.task_arrival >= 16'(now_reg))
                    begin
                        future_reg <= 1'b1;
                    end
                end
            end
            if (cmd.tick_start)
            begin
                idx_reg          <= '0;
                future_reg       <= 1'b0;
                res_accepted_reg <= 1'b0;
                res_ran_reg      <= 1'b0;
                res_slot_reg     <= '0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + SW'(1);
                if (scan_future)
                begin
                    future_reg <= 1'b1;
                end
                if (push_ok)
                begin
                    tail_reg[lv_sel] <= next_pos(tail_sel);
                    fill_reg[lv_sel] <= fill_sel + CW'(1);
                end
            end
            if (cmd.advance)
            begin
                now_reg     <= now_inc;
                pending_reg <= 1'b0;
            end
            // A rotation pops the front and pushes it back, so the fill stays.
            if (cmd.rot_wr)
            begin
                head_reg[lv_sel] <= next_pos(head_sel);
                tail_reg[lv_sel] <= next_pos(tail_sel);
            end
            if (cmd.sel)
            begin
                sel_lv_reg <= enc_lv;
            end
            if (cmd.run)
            begin
                progress_reg[run_slot] <= prog_inc;
                res_ran_reg            <= 1'b1;
                res_slot_reg           <= run_slot;
                if (remain != 16'd0)
                begin
                    if (policy_reg[run_slot])
                    begin
                        pending_reg <= 1'b1;
                        rot_lv_reg  <= sel_lv_reg;
                    end
                end
                else
                begin
                    head_reg[lv_sel] <= next_pos(head_sel);
                    fill_reg[lv_sel] <= fill_sel - CW'(1);
                end
            end
        end
    end

    assign slot_wide = 8'(res_slot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.accepted  <= res_accepted_reg;
            out_reg.ran       <= res_ran_reg;
            out_reg.task_slot <= slot_wide[3:0];
            out_reg.active    <= (now_reg <= limit_reg) && (future_reg || (|ne));
            out_reg.now       <= now_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: design/priority_fifo_rr_scheduler.sv
// Priority scheduler with per-level FIFO/round-robin queues; top level.
// Order of work: a load item passes from idle straight to the done state, where its result loads;
// a tick item scans the loaded task slots, one slot a cycle, then advances the clock, optionally
// rotates a round-robin queue (read, then write), selects a level and optionally runs its task.
// One item in work at a time: the next is accepted in the cycle after its result loads, and
// later while out_stall holds an earlier result.
// rst_n clears the clock, task count, queues and handshake state at once; limit back to 2048.
module priority_fifo_rr_scheduler
    import prr_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int LEVELS    = LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [NOW_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t stat;

    prr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_func   (in_data.func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    prr_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .LEVELS    (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

    // The result register is only refilled once the previous item has gone.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register overwritten while an item waits");

    // A load is only performed for an accepted load item.
    a_load_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && !in_stall && (in_data.func == FUNC_LOAD)))
        else $error("load issued without an accepted load item");

    // The rotation write uses the data read in the cycle before.
    a_rot_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_wr |-> $past(cmd.rot_rd))
        else $error("rotation write without a preceding read");

endmodule
